[rtl/hfa_pkg.sv]
// hfa_pkg: shared types, codes and default sizes for the hole-fit allocator.
// No dependencies; compiled first.
`default_nettype none

package hfa_pkg;

  // Default table geometry
  localparam int unsigned MAX_HOLES_DEFAULT = 16;
  localparam int unsigned SIZE_BITS_DEFAULT = 16;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_ALLOC   = 2'd1,
    REQ_RESTORE = 2'd2
  } req_type_e;

  // Fit policies (code 3 falls back to first fit)
  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_mode_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_FIT_MODE     = 2'd0,
    CFG_HOLES_IN_USE = 2'd1
  } cfg_index_e;

  // Request beat
  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  hole_slot;
    logic [15:0] size_value;
  } req_t;

  // Response beat
  typedef struct packed {
    logic        granted;
    logic [3:0]  chosen_hole;
    logic [15:0] left_in_hole;
  } rsp_t;

  // Configuration write beat
  typedef struct packed {
    logic [1:0] reg_index;
    logic [4:0] wdata;
  } cfg_t;

  // Register file contents seen by the sequencer
  typedef struct packed {
    logic [1:0] fit_mode;
    logic [4:0] holes_in_use;
  } cfg_state_t;

endpackage

`default_nettype wire

[rtl/hfa_chan_if.sv]
// hfa_chan_if: valid/ready channel carrying one payload beat of type T.
// Used for the request, response and configuration channels; no dependencies.
`default_nettype none

interface hfa_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/hfa_ram.sv]
// hfa_ram: generic single-write, single-read RAM with registered read data.
// No package dependency.
`default_nettype none

module hfa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/hfa_cfg_regs.sv]
// hfa_cfg_regs: fit mode and holes-in-use registers behind the config channel.
// Depends on hfa_pkg and hfa_chan_if.
`default_nettype none

module hfa_cfg_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  hfa_chan_if.sink           cfg_i,
  output hfa_pkg::cfg_state_t cfg_st_o
);
  import hfa_pkg::*;

  cfg_state_t st_q, st_d;

  // Always able to take a write
  assign cfg_i.ready = 1'b1;

  // Register decode
  always_comb begin
    st_d = st_q;
    if (cfg_i.valid) begin
      case (cfg_i.data.reg_index)
        CFG_FIT_MODE:     st_d.fit_mode     = cfg_i.data.wdata[1:0];
        CFG_HOLES_IN_USE: st_d.holes_in_use = cfg_i.data.wdata;
        default:          st_d = st_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign cfg_st_o = st_q;

endmodule

`default_nettype wire

[rtl/hfa_seq.sv]
// hfa_seq: request sequencer; loads, scans, writes back and restores the two
// size tables held in hfa_ram instances. Depends on hfa_pkg and hfa_chan_if.
`default_nettype none

module hfa_seq #(
  parameter int unsigned MAX_HOLES = hfa_pkg::MAX_HOLES_DEFAULT,
  parameter int unsigned SIZE_BITS = hfa_pkg::SIZE_BITS_DEFAULT,
  localparam int unsigned IdxW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  hfa_chan_if.sink                req_i,
  hfa_chan_if.source              rsp_o,
  input  hfa_pkg::cfg_state_t     cfg_st_i,
  // table RAM ports
  output logic [IdxW-1:0]         raddr_o,
  input  wire logic [SIZE_BITS-1:0] orig_rdata_i,
  input  wire logic [SIZE_BITS-1:0] rem_rdata_i,
  output logic                    orig_we_o,
  output logic                    rem_we_o,
  output logic [IdxW-1:0]         waddr_o,
  output logic [SIZE_BITS-1:0]    orig_wdata_o,
  output logic [SIZE_BITS-1:0]    rem_wdata_o
);
  import hfa_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_HOLES + 1);
  localparam int unsigned SizeW = SIZE_BITS;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_SCAN    = 4'b0010,
    S_RESTORE = 4'b0100,
    S_DONE    = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]   rd_idx_q, rd_idx_d;
  logic              found_q, found_d;
  logic [IdxW-1:0]   best_idx_q, best_idx_d;
  logic [SizeW-1:0]  best_val_q, best_val_d;
  logic [SizeW-1:0]  size_q, size_d;
  logic              res_grant_q, res_grant_d;
  logic [IdxW-1:0]   res_idx_q, res_idx_d;
  logic [SizeW-1:0]  res_left_q, res_left_d;
  logic              out_vld_q, out_vld_d;
  rsp_t              out_q, out_d;

  logic              accept;
  logic [47:0]       size_ext;
  logic [SizeW-1:0]  size_in;
  logic [IdxW+3:0]   slot_ext;
  logic              slot_ok;
  logic [CntW-1:0]   lim;
  logic              fits;
  logic              take;
  logic [SizeW-1:0]  diff;
  logic [IdxW+3:0]   res_idx_ext;
  logic [SizeW+15:0] res_left_ext;

  // Request field conditioning
  assign size_ext = {32'd0, req_i.data.size_value};
  assign size_in  = size_ext[SizeW-1:0];
  assign slot_ext = {{IdxW{1'b0}}, req_i.data.hole_slot};
  assign slot_ok  = 32'(req_i.data.hole_slot) < 32'(MAX_HOLES);

  // Entries taking part, clamped to the table depth
  assign lim = (32'(cfg_st_i.holes_in_use) > 32'(MAX_HOLES)) ?
               CntW'(MAX_HOLES) : CntW'(cfg_st_i.holes_in_use);

  // Candidate test on the entry just read
  assign fits = rem_rdata_i >= size_q;
  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!found_q) begin
        take = 1'b1;
      end else if (cfg_st_i.fit_mode == FIT_BEST) begin
        take = rem_rdata_i < best_val_q;
      end else if (cfg_st_i.fit_mode == FIT_WORST) begin
        take = rem_rdata_i > best_val_q;
      end
    end
  end

  assign diff = best_val_q - size_q;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  assign res_idx_ext  = {4'd0, res_idx_q};
  assign res_left_ext = {16'd0, res_left_q};

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_val_d   = best_val_q;
    size_d       = size_q;
    res_grant_d  = res_grant_q;
    res_idx_d    = res_idx_q;
    res_left_d   = res_left_q;
    out_vld_d    = out_vld_q;
    out_d        = out_q;
    orig_we_o    = 1'b0;
    rem_we_o     = 1'b0;
    waddr_o      = slot_ext[IdxW-1:0];
    orig_wdata_o = size_in;
    rem_wdata_o  = size_in;

    // response slot drains
    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          size_d      = size_in;
          res_grant_d = 1'b0;
          res_idx_d   = '0;
          res_left_d  = '0;
          cnt_d       = '0;
          found_d     = 1'b0;
          case (req_i.data.req_type)
            REQ_LOAD: begin
              orig_we_o = slot_ok;
              rem_we_o  = slot_ok;
              state_d   = S_DONE;
            end
            REQ_ALLOC:   state_d = S_SCAN;
            REQ_RESTORE: state_d = S_RESTORE;
            default:     state_d = S_DONE;
          endcase
        end
      end

      S_SCAN: begin
        // issue reads over the entries in use
        if (cnt_q < lim) begin
          rd_vld_d = 1'b1;
          rd_idx_d = cnt_q[IdxW-1:0];
          cnt_d    = cnt_q + CntW'(1);
        end
        // fold in the entry returned this cycle
        if (rd_vld_q && take) begin
          found_d    = 1'b1;
          best_idx_d = rd_idx_q;
          best_val_d = rem_rdata_i;
        end
        // scan drained: write back the chosen entry
        if (!(cnt_q < lim) && !rd_vld_q) begin
          state_d = S_DONE;
          if (found_q) begin
            rem_we_o    = 1'b1;
            waddr_o     = best_idx_q;
            rem_wdata_o = diff;
            res_grant_d = 1'b1;
            res_idx_d   = best_idx_q;
            res_left_d  = diff;
          end
        end
      end

      S_RESTORE: begin
        if (cnt_q != CntW'(MAX_HOLES)) begin
          rd_vld_d = 1'b1;
          rd_idx_d = cnt_q[IdxW-1:0];
          cnt_d    = cnt_q + CntW'(1);
        end
        if (rd_vld_q) begin
          rem_we_o    = 1'b1;
          waddr_o     = rd_idx_q;
          rem_wdata_o = orig_rdata_i;
        end
        if (cnt_q == CntW'(MAX_HOLES) && !rd_vld_q) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d         = 1'b1;
          out_d.granted      = res_grant_q;
          out_d.chosen_hole  = res_idx_ext[3:0];
          out_d.left_in_hole = res_left_ext[15:0];
          state_d           = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Both tables share the sweep counter as read address
  assign raddr_o = cnt_q[IdxW-1:0];

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    best_idx_q  <= best_idx_d;
    best_val_q  <= best_val_d;
    size_q      <= size_d;
    res_grant_q <= res_grant_d;
    res_idx_q   <= res_idx_d;
    res_left_q  <= res_left_d;
    out_q       <= out_d;
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

`ifndef SYNTHESIS
  // an accepted beat always moves the sequencer out of idle
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("sequencer stayed idle after accepting a request");

  // table reads are only in flight while sweeping
  a_read_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == S_SCAN || state_q == S_RESTORE))
    else $error("read data returned outside a sweep");

  // remaining-size writes come only from a load, a write-back or a restore
  a_rem_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_we_o |-> (accept || state_q == S_SCAN || state_q == S_RESTORE))
    else $error("unexpected remaining-size write");

  // a new response is only raised from the done state
  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_d && !out_vld_q) |-> state_q == S_DONE)
    else $error("response raised outside the done state");
`endif

endmodule

`default_nettype wire

[rtl/hole_fit_allocator_unit.sv]
// Hole-fit allocator: table of holes with first/best/worst fit allocation.
// Flow (accept to response valid): load and unknown kinds go straight to done;
//   allocate reads one table entry per hole in use, then writes back the
//   chosen entry if one fits; restore copies every original entry back.
// Throughput: one item at a time; the next request is taken in the same cycle as
//   the response is raised, once the done state finds the response slot free.
// Reset: registers, sequencer and response slot cleared; tables hold no reset
//   value and must be loaded before use.
`default_nettype none

module hole_fit_allocator_unit #(
  parameter int unsigned MAX_HOLES = hfa_pkg::MAX_HOLES_DEFAULT,
  parameter int unsigned SIZE_BITS = hfa_pkg::SIZE_BITS_DEFAULT
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hfa_chan_if.sink   req_i,
  hfa_chan_if.source rsp_o,
  hfa_chan_if.sink   cfg_i
);
  import hfa_pkg::*;

  localparam int unsigned IdxW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;

  cfg_state_t          cfg_st;
  logic [IdxW-1:0]     raddr;
  logic [SIZE_BITS-1:0] orig_rdata, rem_rdata;
  logic                orig_we, rem_we;
  logic [IdxW-1:0]     waddr;
  logic [SIZE_BITS-1:0] orig_wdata, rem_wdata;

  // Configuration registers
  hfa_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .cfg_st_o (cfg_st)
  );

  // Request sequencer
  hfa_seq #(
    .MAX_HOLES (MAX_HOLES),
    .SIZE_BITS (SIZE_BITS)
  ) u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .req_i              (req_i),
    .rsp_o              (rsp_o),
    .cfg_st_i           (cfg_st),
    .raddr_o            (raddr),
    .orig_rdata_i       (orig_rdata),
    .rem_rdata_i        (rem_rdata),
    .orig_we_o          (orig_we),
    .rem_we_o           (rem_we),
    .waddr_o            (waddr),
    .orig_wdata_o       (orig_wdata),
    .rem_wdata_o        (rem_wdata)
  );

  // Original sizes
  hfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_HOLES)
  ) u_orig_ram (
    .clk_i   (clk_i),
    .we_i    (orig_we),
    .waddr_i (waddr),
    .wdata_i (orig_wdata),
    .raddr_i (raddr),
    .rdata_o (orig_rdata)
  );

  // Remaining sizes
  hfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_HOLES)
  ) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (waddr),
    .wdata_i (rem_wdata),
    .raddr_i (raddr),
    .rdata_o (rem_rdata)
  );

endmodule

`default_nettype wire
